>>> src/tfv_pkg.sv
// shared types, codes and character helpers for the text frame validator
package tfv_pkg;

	localparam int LEN_W       = 16;
	localparam int OPT_KEY_MAX = 32;

	// beat op codes
	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_LAST = 2'd1;
	localparam logic [1:0] OP_END  = 2'd2;
	localparam logic [1:0] OP_NOP  = 2'd3;

	// verdict codes
	localparam logic [3:0] ERR_NONE    = 4'd0;
	localparam logic [3:0] ERR_COUNT   = 4'd1;
	localparam logic [3:0] ERR_EMPTY   = 4'd2;
	localparam logic [3:0] ERR_TYPE    = 4'd3;
	localparam logic [3:0] ERR_ID      = 4'd4;
	localparam logic [3:0] ERR_TARGET  = 4'd5;
	localparam logic [3:0] ERR_PAYLOAD = 4'd6;
	localparam logic [3:0] ERR_CTX     = 4'd7;
	localparam logic [3:0] ERR_OPTION  = 4'd8;

	// target kinds
	localparam logic [1:0] TGT_NAMED  = 2'd0;
	localparam logic [1:0] TGT_STAR   = 2'd1;
	localparam logic [1:0] TGT_BROKER = 2'd2;

	// target flag bits
	localparam int TF_FIRST_ALPHA = 0;
	localparam int TF_BAD_CHAR    = 1;
	localparam int TF_STAR        = 2;
	localparam int TF_BROKER_MISS = 3;

	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] frame_byte;
	} in_beat_t;

	typedef struct packed {
		logic [3:0]  error_code;
		logic [3:0]  msg_type;
		logic [31:0] msg_id;
		logic [1:0]  target_kind;
		logic [7:0]  arg_count;
		logic [7:0]  option_count;
		logic [7:0]  ctx_ref_count;
	} verdict_t;

	function automatic logic is_upper(logic [7:0] c);
		return c >= 8'h41 && c <= 8'h5A;
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return is_upper(c) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_forbidden(logic [7:0] c);
		return c == CH_PIPE || c == CH_LPAR || c == CH_RPAR || c == CH_QUEST ||
			c == CH_AMP || c == CH_EQ;
	endfunction

	function automatic logic [LEN_W-1:0] sat_len(logic [LEN_W-1:0] v);
		return (v != '1) ? v + LEN_W'(1) : v;
	endfunction

	// acc * 10 + digit; bit 32 flags a result past 32 bits
	function automatic logic [32:0] dec_step(logic [31:0] acc, logic [7:0] c);
		logic [35:0] w;
		w = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, c[3:0]};
		return {|w[35:32], w[31:0]};
	endfunction

	function automatic logic [7:0] ctx_char(logic [1:0] i);
		case (i)
			2'd0:    return 8'h43;
			2'd1:    return 8'h54;
			2'd2:    return 8'h58;
			default: return 8'h3A;
		endcase
	endfunction

	function automatic logic [7:0] broker_char(logic [2:0] i);
		case (i)
			3'd0:    return 8'h62;
			3'd1:    return 8'h72;
			3'd2:    return 8'h6F;
			3'd3:    return 8'h6B;
			3'd4:    return 8'h65;
			default: return 8'h72;
		endcase
	endfunction

	// three type letters, first letter in the low byte
	localparam logic [23:0] TYPE_WORDS [9] = '{
		24'h4E5953, 24'h4B4341, 24'h514552, 24'h534552, 24'h525245,
		24'h545645, 24'h544C44, 24'h455942, 24'h544248
	};

	// bit 4 set when found, low bits the type index
	function automatic logic [4:0] type_lookup(logic [23:0] w);
		logic [4:0] r;
		r = '0;
		for (int i = 8; i >= 0; i--) begin
			if (w == TYPE_WORDS[i]) r = {1'b1, 4'(i)};
		end
		return r;
	endfunction

endpackage

>>> src/tfv_stream_if.sv
// valid/ready channel carrying one payload beat
interface tfv_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/text_frame_validator.sv
// text frame validator top level: input stage, frame scanner, verdict register
//
//  channel      dir  payload                                   beat taken when
//  frame_in     in   op, frame_byte                            valid & ready
//  verdict_out  out  error_code, msg_type, msg_id, target_kind, valid & ready
//                    arg_count, option_count, ctx_ref_count
//
// one byte beat a cycle: a beat sits in the input stage, where the
// scanner updates the frame state with a short byte-wide step (times ten add
// for the id) and, on a frame end, forms the verdict into the output register.
// reset clears the input stage, the frame state and the output register.
// the input stalls only while a frame-end beat waits on a full output register.
module text_frame_validator #(
	parameter int MAX_COUNT      = 255,
	parameter int TARGET_MAX_LEN = 32,
	parameter int OP_MAX_LEN     = 16
) (
	input logic clk,
	input logic arst_n,
	tfv_stream_if.sink   frame_in,
	tfv_stream_if.source verdict_out
);
	import tfv_pkg::*;

	// input stage
	logic     valid_s1;
	in_beat_t beat_s1;

	// output register
	logic     out_valid_q;
	verdict_t out_data_q;

	verdict_t verdict;
	logic     ends_s1;
	logic     out_free;
	logic     adv;

	// frame end beats need a free output slot
	assign ends_s1  = beat_s1.op == OP_LAST || beat_s1.op == OP_END;
	assign out_free = !out_valid_q || verdict_out.ready;
	assign adv      = valid_s1 && (!ends_s1 || out_free);

	assign frame_in.ready    = !valid_s1 || adv;
	assign verdict_out.valid = out_valid_q;
	assign verdict_out.data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_in.ready) begin
			valid_s1 <= frame_in.valid;
		end
	end

	// payload holds while stalled
	always_ff @(posedge clk) begin
		if (frame_in.ready && frame_in.valid) beat_s1 <= frame_in.data;
	end

	tfv_frame_state #(
		.MAX_COUNT      (MAX_COUNT),
		.TARGET_MAX_LEN (TARGET_MAX_LEN),
		.OP_MAX_LEN     (OP_MAX_LEN)
	) u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.beat    (beat_s1),
		.verdict (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && ends_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ends_s1) out_data_q <= verdict;
	end

	// a frame end leaving the input stage lands in the output register
	property p_end_to_out;
		@(posedge clk) disable iff (!arst_n) adv && ends_s1 |=> out_valid_q;
	endproperty
	a_end_to_out: assert property (p_end_to_out) else $error("verdict lost");

	// a held beat in the input stage stays put
	property p_s1_hold;
		@(posedge clk) disable iff (!arst_n)
			valid_s1 && !adv |=> valid_s1 && $stable(beat_s1);
	endproperty
	a_s1_hold: assert property (p_s1_hold) else $error("input stage dropped a beat");

	// an error verdict carries no other content
	property p_err_clean;
		@(posedge clk) disable iff (!arst_n)
			out_valid_q && out_data_q.error_code != ERR_NONE |->
			out_data_q.msg_id == 32'd0 && out_data_q.arg_count == 8'd0 &&
			out_data_q.msg_type == 4'd0 && out_data_q.option_count == 8'd0;
	endproperty
	a_err_clean: assert property (p_err_clean) else $error("error verdict with content");

endmodule

>>> src/tfv_frame_state.sv
// per-frame scan state, byte update and end-of-frame verdict
module tfv_frame_state #(
	parameter int MAX_COUNT      = 255,
	parameter int TARGET_MAX_LEN = 32,
	parameter int OP_MAX_LEN     = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  tfv_pkg::in_beat_t beat,
	output tfv_pkg::verdict_t verdict
);
	import tfv_pkg::*;

	localparam int CW = $clog2(MAX_COUNT + 1);

	typedef struct packed {
		logic        nonempty;
		logic        forbidden;
		logic        ctx_dead;
		logic        ctx_digits;
		logic        ctx_bad;
		logic [2:0]  ctx_pos;
		logic [31:0] ctx_acc;
	} arg_t;

	typedef struct packed {
		logic             frame_nonempty;
		logic             any_empty;
		logic [2:0]       field_index;
		logic             field_nz;
		logic [23:0]      type_letters;
		logic [2:0]       type_len;
		logic [31:0]      id_acc;
		logic             id_bad;
		logic [3:0]       tflags;
		logic [LEN_W-1:0] tgt_len;
		logic [1:0]       phase;
		logic [LEN_W-1:0] op_len;
		logic             op_bad;
		arg_t             arg;
		logic             args_seen;
		logic [3:0]       first_fail;
		logic [CW-1:0]    n_args;
		logic [CW-1:0]    n_opts;
		logic [CW-1:0]    n_ctx;
		logic [3:0]       snap_code;
		logic [CW-1:0]    snap_args;
		logic [CW-1:0]    snap_ctx;
		logic             tail_any;
		logic             tail_q;
		logic             opt_any;
		logic             opt_fail;
		logic             opt_eq;
		logic             opt_val;
		logic             key_bad;
		logic [LEN_W-1:0] key_len;
	} fstate_t;

	function automatic logic [CW-1:0] sat_cnt(logic [CW-1:0] v);
		return (v < CW'(MAX_COUNT)) ? v + CW'(1) : CW'(MAX_COUNT);
	endfunction

	function automatic logic [3:0] arg_verdict(arg_t a);
		if (!a.nonempty || a.forbidden) return ERR_PAYLOAD;
		if (a.ctx_pos == 3'd4 && !a.ctx_dead && (!a.ctx_digits || a.ctx_bad)) return ERR_CTX;
		return ERR_NONE;
	endfunction

	function automatic logic arg_is_ctx(arg_t a);
		return arg_verdict(a) == ERR_NONE && a.ctx_pos == 3'd4 && !a.ctx_dead;
	endfunction

	function automatic fstate_t arg_byte(fstate_t s, logic [7:0] c);
		fstate_t     r;
		logic [32:0] dd;
		r = s;
		if (c == CH_COMMA) begin
			if (r.first_fail == ERR_NONE) r.first_fail = arg_verdict(s.arg);
			if (arg_is_ctx(s.arg)) r.n_ctx = sat_cnt(s.n_ctx);
			r.n_args = sat_cnt(s.n_args);
			r.arg = '0;
		end else begin
			r.arg.nonempty = 1'b1;
			if (is_forbidden(c)) r.arg.forbidden = 1'b1;
			if (!s.arg.ctx_dead) begin
				if (s.arg.ctx_pos < 3'd4) begin
					if (c == ctx_char(s.arg.ctx_pos[1:0])) r.arg.ctx_pos = s.arg.ctx_pos + 3'd1;
					else r.arg.ctx_dead = 1'b1;
				end else begin
					r.arg.ctx_digits = 1'b1;
					if (!is_digit(c)) begin
						r.arg.ctx_bad = 1'b1;
					end else if (!s.arg.ctx_bad) begin
						dd = dec_step(s.arg.ctx_acc, c);
						r.arg.ctx_acc = dd[31:0];
						if (dd[32]) r.arg.ctx_bad = 1'b1;
					end
				end
			end
		end
		return r;
	endfunction

	function automatic fstate_t option_close(fstate_t s);
		fstate_t r;
		r = s;
		if (!s.opt_eq || s.key_len == '0 || !s.opt_val || s.key_bad ||
			s.key_len > LEN_W'(OPT_KEY_MAX)) r.opt_fail = 1'b1;
		r.n_opts = sat_cnt(s.n_opts);
		r.opt_eq = 1'b0;
		r.opt_val = 1'b0;
		r.key_bad = 1'b0;
		r.key_len = '0;
		return r;
	endfunction

	function automatic fstate_t tail_byte(fstate_t s, logic [7:0] c);
		fstate_t r;
		r = s;
		if (!s.tail_any) begin
			r.tail_any = 1'b1;
			r.tail_q = (c == CH_QUEST);
		end else if (s.tail_q) begin
			r.opt_any = 1'b1;
			if (c == CH_AMP) begin
				r = option_close(r);
			end else if (!s.opt_eq) begin
				if (c == CH_EQ) begin
					r.opt_eq = 1'b1;
				end else begin
					r.key_len = sat_len(s.key_len);
					if (r.key_len == LEN_W'(1) ? !is_alpha(c)
						: !(is_alpha(c) || is_digit(c) || c == CH_UNDER)) r.key_bad = 1'b1;
				end
			end else begin
				r.opt_val = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic fstate_t payload_byte(fstate_t s, logic [7:0] c);
		fstate_t r;
		r = s;
		if (s.phase == 2'd0) begin
			if (c == CH_LPAR) begin
				r.phase = 2'd1;
			end else begin
				r.op_len = sat_len(s.op_len);
				if (r.op_len == LEN_W'(1) ? !is_upper(c)
					: !(is_upper(c) || is_digit(c) || c == CH_UNDER)) r.op_bad = 1'b1;
			end
		end else if (c == CH_RPAR) begin
			// snapshot of the arg list as if it closed here
			if (!s.args_seen) begin
				r.snap_code = ERR_NONE;
				r.snap_args = '0;
				r.snap_ctx  = '0;
			end else begin
				r.snap_code = (s.first_fail != ERR_NONE) ? s.first_fail : arg_verdict(s.arg);
				r.snap_args = sat_cnt(s.n_args);
				r.snap_ctx  = arg_is_ctx(s.arg) ? sat_cnt(s.n_ctx) : s.n_ctx;
			end
			r.args_seen = 1'b1;
			r = arg_byte(r, c);
			r.phase = 2'd2;
			r.tail_any = 1'b0;
			r.tail_q = 1'b0;
			r.opt_any = 1'b0;
			r.opt_fail = 1'b0;
			r.opt_eq = 1'b0;
			r.opt_val = 1'b0;
			r.key_bad = 1'b0;
			r.key_len = '0;
			r.n_opts = '0;
		end else begin
			r.args_seen = 1'b1;
			r = arg_byte(r, c);
			if (s.phase == 2'd2) r = tail_byte(r, c);
		end
		return r;
	endfunction

	function automatic fstate_t frame_byte_in(fstate_t s, logic [7:0] c);
		fstate_t     r;
		logic [32:0] dd;
		r = s;
		r.frame_nonempty = 1'b1;
		if (c == CH_PIPE) begin
			if (!s.field_nz) r.any_empty = 1'b1;
			r.field_nz = 1'b0;
			if (s.field_index < 3'd4) r.field_index = s.field_index + 3'd1;
		end else begin
			r.field_nz = 1'b1;
			case (s.field_index)
				3'd0: begin
					if (s.type_len < 3'd3) r.type_letters[s.type_len[1:0]*8 +: 8] = c;
					if (s.type_len < 3'd4) r.type_len = s.type_len + 3'd1;
				end
				3'd1: begin
					if (!is_digit(c)) begin
						r.id_bad = 1'b1;
					end else if (!s.id_bad) begin
						dd = dec_step(s.id_acc, c);
						r.id_acc = dd[31:0];
						if (dd[32]) r.id_bad = 1'b1;
					end
				end
				3'd2: begin
					r.tgt_len = sat_len(s.tgt_len);
					if (r.tgt_len == LEN_W'(1)) begin
						if (is_alpha(c)) r.tflags[TF_FIRST_ALPHA] = 1'b1;
						if (c == CH_STAR) r.tflags[TF_STAR] = 1'b1;
					end
					if (!(is_alpha(c) || is_digit(c) || c == CH_UNDER || c == CH_DASH))
						r.tflags[TF_BAD_CHAR] = 1'b1;
					if (r.tgt_len <= LEN_W'(6) && c != broker_char(3'(s.tgt_len)))
						r.tflags[TF_BROKER_MISS] = 1'b1;
				end
				3'd3: r = payload_byte(r, c);
				default: ;
			endcase
		end
		return r;
	endfunction

	fstate_t st_q, ns, oc;
	logic [4:0] tmatch;
	logic       star, broker, named;
	logic [3:0] code;
	logic [CW-1:0] nopts;

	always_comb begin
		ns = st_q;
		if (beat.op == OP_BYTE || beat.op == OP_LAST) ns = frame_byte_in(st_q, beat.frame_byte);
	end

	always_comb begin
		tmatch = type_lookup(ns.type_letters);
		star   = ns.tgt_len == LEN_W'(1) && ns.tflags[TF_STAR];
		broker = ns.tgt_len == LEN_W'(6) && !ns.tflags[TF_BROKER_MISS];
		named  = ns.tgt_len <= LEN_W'(TARGET_MAX_LEN) && ns.tflags[TF_FIRST_ALPHA] &&
			!ns.tflags[TF_BAD_CHAR];
		oc     = option_close(ns);
		nopts  = '0;
		if (!ns.frame_nonempty || ns.field_index != 3'd3) code = ERR_COUNT;
		else if (ns.any_empty || !ns.field_nz) code = ERR_EMPTY;
		else if (!(ns.type_len == 3'd3 && tmatch[4])) code = ERR_TYPE;
		else if (ns.id_bad) code = ERR_ID;
		else if (!(star || broker || named)) code = ERR_TARGET;
		else if (ns.phase != 2'd2 || ns.op_len < LEN_W'(2) ||
			ns.op_len > LEN_W'(OP_MAX_LEN) || ns.op_bad) code = ERR_PAYLOAD;
		else if (ns.tail_any && !ns.tail_q) code = ERR_PAYLOAD;
		else if (ns.snap_code != ERR_NONE) code = ns.snap_code;
		else if (ns.tail_any) begin
			if (!ns.opt_any || oc.opt_fail) code = ERR_OPTION;
			else code = ERR_NONE;
			nopts = oc.n_opts;
		end else code = ERR_NONE;

		verdict = '0;
		verdict.error_code = code;
		if (code == ERR_NONE) begin
			verdict.msg_type      = tmatch[3:0];
			verdict.msg_id        = ns.id_acc;
			verdict.target_kind   = star ? TGT_STAR : (broker ? TGT_BROKER : TGT_NAMED);
			verdict.arg_count     = 8'(ns.snap_args);
			verdict.option_count  = 8'(nopts);
			verdict.ctx_ref_count = 8'(ns.snap_ctx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			if (beat.op == OP_LAST || beat.op == OP_END) st_q <= '0;
			else st_q <= ns;
		end
	end

	property p_index_sat;
		@(posedge clk) disable iff (!arst_n) st_q.field_index <= 3'd4;
	endproperty
	a_index_sat: assert property (p_index_sat) else $error("field index past four");

	property p_end_clears;
		@(posedge clk) disable iff (!arst_n)
			step && (beat.op == OP_LAST || beat.op == OP_END) |=> st_q == '0;
	endproperty
	a_end_clears: assert property (p_end_clears) else $error("state not cleared at frame end");

	property p_ctx_pos;
		@(posedge clk) disable iff (!arst_n) st_q.arg.ctx_pos <= 3'd4;
	endproperty
	a_ctx_pos: assert property (p_ctx_pos) else $error("context prefix position overrun");

endmodule

>>> tb/text_frame_validator_tb.sv
// self-checking testbench for the text frame validator: frame stimulus, verdict prediction
module text_frame_validator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tfv_pkg::*;

	localparam int MAX_COUNT      = 255;
	localparam int TARGET_MAX_LEN = 32;
	localparam int OP_MAX_LEN     = 16;
	localparam int LEN_CAP        = 16'hFFFF;
	localparam longint unsigned U32_TOP = 64'hFFFF_FFFF;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int DRAIN_CYCLES   = 20;

	logic clk;
	logic arst_n;

	tfv_stream_if #(.T(in_beat_t)) frame_in ();
	tfv_stream_if #(.T(verdict_t)) verdict_out ();

	text_frame_validator #(
		.MAX_COUNT(MAX_COUNT),
		.TARGET_MAX_LEN(TARGET_MAX_LEN),
		.OP_MAX_LEN(OP_MAX_LEN)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame_in(frame_in),
		.verdict_out(verdict_out)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// frame scanner mirror: state cleared at the start of the run and after every frame end
	// ------------------------------------------------------------------
	bit              fr_nonempty, any_empty;
	int unsigned     fld_idx, fld_len;
	bit [23:0]       type_chars;
	int unsigned     type_len;
	longint unsigned id_acc;
	bit              id_bad;
	bit [3:0]        tgt_flags;
	int unsigned     tgt_len;
	int unsigned     pay_phase;
	int unsigned     op_len;
	bit              op_bad;
	// current argument
	bit              a_nonempty, a_forbid, a_dead, a_digits, a_bad;
	int unsigned     a_pos;
	longint unsigned a_acc;
	bit              args_seen;
	logic [3:0]      first_fail;
	int unsigned     n_args, n_opts, n_refs;
	logic [3:0]      snap_code;
	int unsigned     snap_args, snap_refs;
	// text after the last ')'
	bit              tail_any, tail_q, opt_any, opt_fail, opt_eq, opt_val, key_bad;
	int unsigned     key_len;

	verdict_t verdicts_due[$];
	in_beat_t pending_beats[$];

	string ctx_txt    = "CTX:";
	string broker_txt = "broker";

	function automatic bit alpha_ch(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit digit_ch(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic int unsigned count_up(int unsigned v);
		return v < MAX_COUNT ? v + 1 : MAX_COUNT;
	endfunction

	function automatic int unsigned len_up(int unsigned v);
		return v < LEN_CAP ? v + 1 : LEN_CAP;
	endfunction

	task automatic clear_frame();
		fr_nonempty = 0; any_empty = 0; fld_idx = 0; fld_len = 0;
		type_chars = '0; type_len = 0; id_acc = 0; id_bad = 0;
		tgt_flags = '0; tgt_len = 0; pay_phase = 0; op_len = 0; op_bad = 0;
		a_nonempty = 0; a_forbid = 0; a_dead = 0; a_digits = 0; a_bad = 0;
		a_pos = 0; a_acc = 0; args_seen = 0; first_fail = ERR_NONE;
		n_args = 0; n_opts = 0; n_refs = 0;
		snap_code = ERR_NONE; snap_args = 0; snap_refs = 0;
		tail_any = 0; tail_q = 0; opt_any = 0; opt_fail = 0;
		opt_eq = 0; opt_val = 0; key_bad = 0; key_len = 0;
	endtask

	function automatic logic [3:0] arg_code();
		if (!a_nonempty || a_forbid) return ERR_PAYLOAD;
		if (a_pos == 4 && !a_dead && (!a_digits || a_bad)) return ERR_CTX;
		return ERR_NONE;
	endfunction

	function automatic bit arg_is_ref();
		return arg_code() == ERR_NONE && a_pos == 4 && !a_dead;
	endfunction

	task automatic arg_char(logic [7:0] c);
		if (c == CH_COMMA) begin
			if (first_fail == ERR_NONE) first_fail = arg_code();
			if (arg_is_ref()) n_refs = count_up(n_refs);
			n_args = count_up(n_args);
			a_nonempty = 0; a_forbid = 0; a_dead = 0; a_digits = 0; a_bad = 0;
			a_pos = 0; a_acc = 0;
			return;
		end
		a_nonempty = 1;
		if (c == CH_PIPE || c == CH_LPAR || c == CH_RPAR || c == CH_QUEST ||
				c == CH_AMP || c == CH_EQ)
			a_forbid = 1;
		if (a_dead) return;
		if (a_pos < 4) begin
			if (c == ctx_txt[a_pos]) a_pos++;
			else a_dead = 1;
			return;
		end
		a_digits = 1;
		if (!digit_ch(c)) begin
			a_bad = 1;
		end else if (!a_bad) begin
			a_acc = a_acc * 10 + (c - "0");
			if (a_acc > U32_TOP) a_bad = 1;
		end
	endtask

	function automatic void close_option();
		if (!opt_eq || key_len == 0 || !opt_val || key_bad || key_len > OPT_KEY_MAX)
			opt_fail = 1;
		n_opts = count_up(n_opts);
		opt_eq = 0; opt_val = 0; key_bad = 0; key_len = 0;
	endfunction

	task automatic tail_char(logic [7:0] c);
		if (!tail_any) begin
			tail_any = 1;
			tail_q = (c == CH_QUEST);
			return;
		end
		if (!tail_q) return;
		opt_any = 1;
		if (c == CH_AMP) begin
			close_option();
		end else if (!opt_eq) begin
			if (c == CH_EQ) begin
				opt_eq = 1;
			end else begin
				key_len = len_up(key_len);
				if (key_len == 1 ? !alpha_ch(c) : !(alpha_ch(c) || digit_ch(c) || c == CH_UNDER))
					key_bad = 1;
			end
		end else begin
			opt_val = 1;
		end
	endtask

	task automatic payload_char(logic [7:0] c);
		if (pay_phase == 0) begin
			if (c == CH_LPAR) begin
				pay_phase = 1;
				return;
			end
			op_len = len_up(op_len);
			if (op_len == 1 ? !(c >= "A" && c <= "Z")
					: !((c >= "A" && c <= "Z") || digit_ch(c) || c == CH_UNDER))
				op_bad = 1;
			return;
		end
		if (c == CH_RPAR) begin
			// snapshot as if this ')' were the last one
			if (!args_seen) begin
				snap_code = ERR_NONE; snap_args = 0; snap_refs = 0;
			end else begin
				snap_code = first_fail != ERR_NONE ? first_fail : arg_code();
				snap_args = count_up(n_args);
				snap_refs = arg_is_ref() ? count_up(n_refs) : n_refs;
			end
			args_seen = 1;
			arg_char(c);
			pay_phase = 2;
			tail_any = 0; tail_q = 0; opt_any = 0; opt_fail = 0;
			opt_eq = 0; opt_val = 0; key_bad = 0; key_len = 0;
			n_opts = 0;
			return;
		end
		args_seen = 1;
		arg_char(c);
		if (pay_phase == 2) tail_char(c);
	endtask

	task automatic frame_char(logic [7:0] c);
		fr_nonempty = 1;
		if (c == CH_PIPE) begin
			if (fld_len == 0) any_empty = 1;
			fld_len = 0;
			if (fld_idx < 4) fld_idx++;
			return;
		end
		fld_len = len_up(fld_len);
		case (fld_idx)
			0: begin
				if (type_len < 3) type_chars[8*type_len +: 8] = c;
				if (type_len < 4) type_len++;
			end
			1: begin
				if (!digit_ch(c)) begin
					id_bad = 1;
				end else if (!id_bad) begin
					id_acc = id_acc * 10 + (c - "0");
					if (id_acc > U32_TOP) id_bad = 1;
				end
			end
			2: begin
				tgt_len = len_up(tgt_len);
				if (tgt_len == 1) begin
					if (alpha_ch(c)) tgt_flags[TF_FIRST_ALPHA] = 1;
					if (c == CH_STAR) tgt_flags[TF_STAR] = 1;
				end
				if (!(alpha_ch(c) || digit_ch(c) || c == CH_UNDER || c == CH_DASH))
					tgt_flags[TF_BAD_CHAR] = 1;
				if (tgt_len <= 6 && c != broker_txt[tgt_len-1])
					tgt_flags[TF_BROKER_MISS] = 1;
			end
			3: payload_char(c);
			default: ;
		endcase
	endtask

	// forms the verdict of the frame that ends now
	function automatic verdict_t frame_verdict();
		verdict_t v;
		logic [3:0] code;
		int tidx;
		bit star, brk, named;
		int unsigned nopts;
		code = ERR_NONE;
		nopts = 0;
		tidx = 9;
		for (int i = 0; i < 9; i++) begin
			if (tidx == 9 && type_len == 3 && type_chars == TYPE_WORDS[i]) tidx = i;
		end
		star  = tgt_len == 1 && tgt_flags[TF_STAR];
		brk   = tgt_len == 6 && !tgt_flags[TF_BROKER_MISS];
		named = tgt_len <= TARGET_MAX_LEN && tgt_flags[TF_FIRST_ALPHA] &&
			!tgt_flags[TF_BAD_CHAR];
		if (!fr_nonempty || fld_idx != 3) code = ERR_COUNT;
		else if (any_empty || fld_len == 0) code = ERR_EMPTY;
		else if (tidx == 9) code = ERR_TYPE;
		else if (id_bad) code = ERR_ID;
		else if (!(star || brk || named)) code = ERR_TARGET;
		else if (pay_phase != 2 || op_len < 2 || op_len > OP_MAX_LEN || op_bad)
			code = ERR_PAYLOAD;
		else if (tail_any && !tail_q) code = ERR_PAYLOAD;
		else if (snap_code != ERR_NONE) code = snap_code;
		else if (tail_any) begin
			if (!opt_any) begin
				code = ERR_OPTION;
			end else begin
				close_option();
				if (opt_fail) code = ERR_OPTION;
				nopts = n_opts;
			end
		end
		v = '0;
		v.error_code = code;
		if (code == ERR_NONE) begin
			v.msg_type      = 4'(tidx);
			v.msg_id        = id_acc[31:0];
			v.target_kind   = star ? TGT_STAR : (brk ? TGT_BROKER : TGT_NAMED);
			v.arg_count     = snap_args[7:0];
			v.option_count  = nopts[7:0];
			v.ctx_ref_count = snap_refs[7:0];
		end
		return v;
	endfunction

	// one accepted input beat through the mirror
	task automatic scan_beat(in_beat_t b);
		if (b.op == OP_NOP) return;
		if (b.op != OP_END) frame_char(b.frame_byte);
		if (b.op == OP_BYTE) return;
		verdicts_due.insert(verdicts_due.size(), frame_verdict());
		clear_frame();
	endtask

	// ------------------------------------------------------------------
	// frame text builders
	// ------------------------------------------------------------------
	byte unsigned frame_txt[$];
	int hold_mark = -1;
	int frames_queued;

	task automatic add_str(string s);
		for (int i = 0; i < s.len(); i++) frame_txt.insert(frame_txt.size(), s[i]);
	endtask

	function automatic string rand_word(int n, bit upper);
		string s;
		s = "";
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 2))
				0: s = {s, string'(byte'(upper ? $urandom_range("A", "Z") : $urandom_range("a", "z")))};
				1: s = {s, string'(byte'($urandom_range("0", "9")))};
				default: s = {s, upper ? "_" : string'(byte'($urandom_range("A", "Z")))};
			endcase
		end
		return s;
	endfunction

	// queue the built text as beats; last byte closes the frame or a bare end follows
	task automatic emit_frame(bit bare_end);
		in_beat_t b;
		for (int i = 0; i < frame_txt.size(); i++) begin
			if ($urandom_range(0, 29) == 0) begin
				b.op = OP_NOP;
				b.frame_byte = 8'($urandom_range(0, 255));
				pending_beats.insert(pending_beats.size(), b);
			end
			b.op = (!bare_end && i == frame_txt.size() - 1) ? OP_LAST : OP_BYTE;
			b.frame_byte = frame_txt[i];
			pending_beats.insert(pending_beats.size(), b);
		end
		if (bare_end || frame_txt.size() == 0) begin
			b.op = OP_END;
			b.frame_byte = 8'($urandom_range(0, 255));
			pending_beats.insert(pending_beats.size(), b);
		end
		frame_txt.delete();
		frames_queued++;
	endtask

	task automatic build_random_frame();
		string types [9] = '{"SYN", "ACK", "REQ", "RES", "ERR", "EVT", "DLT", "BYE", "HBT"};
		int nargs;
		int nopt;
		frame_txt.delete();
		// type field
		case ($urandom_range(0, 19))
			0: add_str(rand_word($urandom_range(2, 4), 1));
			1: add_str("syn");
			default: add_str(types[$urandom_range(0, 8)]);
		endcase
		add_str("|");
		// id field
		case ($urandom_range(0, 19))
			0: add_str("4294967296");
			1: add_str("4294967295");
			2: add_str("12a4");
			3: add_str("99999999999");
			default: add_str($sformatf("%0d", $urandom_range(0, 32'hFFFF_FFFF) >> $urandom_range(0, 31)));
		endcase
		add_str("|");
		// target field
		case ($urandom_range(0, 11))
			0: add_str("*");
			1: add_str("broker");
			2: add_str("broke");
			3: add_str("9node");
			4: add_str("a.b");
			5: add_str({"t", rand_word(32, 0)});
			6: add_str("**");
			default: add_str({"n", rand_word($urandom_range(0, 12), 0), "-x"});
		endcase
		add_str("|");
		// payload: op name
		case ($urandom_range(0, 14))
			0: add_str("P");
			1: add_str("op");
			2: add_str({"L", rand_word(16, 1)});
			default: add_str({"Q", rand_word($urandom_range(1, 8), 1)});
		endcase
		if ($urandom_range(0, 14) != 0) begin
			add_str("(");
			nargs = $urandom_range(0, 4);
			for (int i = 0; i < nargs; i++) begin
				if (i > 0) add_str(",");
				case ($urandom_range(0, 11))
					0: add_str("");
					1: add_str("CTX:");
					2: add_str("CTX:4294967296");
					3: add_str("CTX:1x");
					4: add_str("a(b");
					5: add_str("a)b");
					6: add_str("CT");
					7, 8: add_str($sformatf("CTX:%0d", $urandom_range(0, 99999)));
					default: add_str(rand_word($urandom_range(1, 6), 0));
				endcase
			end
			if ($urandom_range(0, 9) != 0) add_str(")");
		end
		// options after the last ')'
		case ($urandom_range(0, 9))
			0: add_str("?");
			1: add_str("x?a=b");
			2: add_str({"?k", rand_word(32, 0), "=v"});
			3: add_str("?=v&a=");
			4, 5, 6: begin
				add_str("?");
				nopt = $urandom_range(1, 4);
				for (int i = 0; i < nopt; i++) begin
					if (i > 0) add_str("&");
					add_str({"k", rand_word($urandom_range(0, 5), 0), "=", rand_word($urandom_range(1, 4), 0)});
				end
			end
			default: ;
		endcase
		// occasional corruption: any byte value, pipes dropped or added
		if ($urandom_range(0, 9) == 0 && frame_txt.size() > 0)
			frame_txt[$urandom_range(0, frame_txt.size() - 1)] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 29) == 0) add_str("|x");
		emit_frame($urandom_range(0, 1));
	endtask

	// ------------------------------------------------------------------
	// driver: bursts of random length with random gaps
	// ------------------------------------------------------------------
	int beats_taken;
	int beats_popped;
	int burst_left;
	int gap_left;
	bit hold_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_in.valid <= 1'b0;
			frame_in.data  <= '0;
			beats_taken    <= 0;
			beats_popped   <= 0;
			burst_left     <= 0;
			gap_left       <= 0;
			hold_req       <= 1'b0;
		end else begin
			if (frame_in.valid && frame_in.ready) begin
				scan_beat(frame_in.data);
				beats_taken <= beats_taken + 1;
			end
			if (!frame_in.valid || frame_in.ready) begin
				if (gap_left > 0) begin
					gap_left       <= gap_left - 1;
					frame_in.valid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					frame_in.valid <= 1'b1;
					frame_in.data  <= pending_beats.pop_front();
					beats_popped   <= beats_popped + 1;
					// receiver hold-off starts with the run of bare frame ends
					if (beats_popped == hold_mark) hold_req <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					frame_in.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: always-ready, random and periodic stall patterns in turn, one long hold-off
	// ------------------------------------------------------------------
	int cycle_cnt;
	int hold_left;
	bit hold_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_out.ready <= 1'b0;
			hold_left         <= 0;
			hold_done         <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done         <= 1'b1;
			hold_left         <= 400;
			verdict_out.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left         <= hold_left - 1;
			verdict_out.ready <= 1'b0;
		end else begin
			case ((cycle_cnt / 150) % 3)
				0:       verdict_out.ready <= 1'b1;
				1:       verdict_out.ready <= $urandom_range(0, 3) != 0;
				default: verdict_out.ready <= (cycle_cnt % 5) < 2;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// monitor: each verdict beat against the oldest expectation
	// ------------------------------------------------------------------
	int errors;
	int verdicts_seen;
	int verdicts_ok;

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		verdict_t want;
		verdict_t got;
		if (arst_n && verdict_out.valid && verdict_out.ready) begin
			got = verdict_out.data;
			verdicts_seen++;
			if (verdicts_due.size() == 0) begin
				$display("%0t: unexpected verdict beat, actual %h", $time, got);
				errors++;
			end else begin
				want = verdicts_due.pop_front();
				if (want.error_code == ERR_NONE) verdicts_ok++;
				check_field("error_code", want.error_code, got.error_code);
				check_field("msg_type", want.msg_type, got.msg_type);
				check_field("msg_id", want.msg_id, got.msg_id);
				check_field("target_kind", want.target_kind, got.target_kind);
				check_field("arg_count", want.arg_count, got.arg_count);
				check_field("option_count", want.option_count, got.option_count);
				check_field("ctx_ref_count", want.ctx_ref_count, got.ctx_ref_count);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int total;
		errors = 0;
		verdicts_seen = 0;
		verdicts_ok = 0;
		frames_queued = 0;
		clear_frame();
		arst_n = 1'b0;

		// directed: empty frame, clean frames, one per error code, bare end
		emit_frame(1);
		add_str("SYN|0|*|OP()");                               emit_frame(0);
		add_str("HBT|4294967295|broker|OP_1(a,CTX:7)?k=v&q1=2"); emit_frame(1);
		add_str("XYZ|1|a|OP()");                               emit_frame(0);
		add_str("RES||a|OP()");                                emit_frame(0);
		add_str("ACK|4294967296|a|OP()");                      emit_frame(0);
		add_str("REQ|1|9a|OP()");                              emit_frame(0);
		add_str("REQ|1|a|OP(a(b))");                           emit_frame(0);
		add_str("REQ|1|a|OP(CTX:)");                           emit_frame(0);
		add_str("REQ|1|a|OP()?");                              emit_frame(0);

		// random frames, with a run of bare frame ends during the long hold-off
		for (int f = 0; f < 10; f++) begin
			if (f == 4) begin
				hold_mark = pending_beats.size();
				for (int k = 0; k < 30; k++) emit_frame(1);
			end
			build_random_frame();
		end
		total = pending_beats.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		wait (beats_taken == total && verdicts_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d input beats in %0d frames, %0d verdicts checked, %0d of them clean",
			total, frames_queued, verdicts_seen, verdicts_ok);
		$display("covered every error code, bursty input, random output stalls and one long hold-off");
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
